[design/stm_pkg.sv]
// Package with constants, codes and types for the sorted identifier table.
`timescale 1ns / 1ps
package stm_pkg;
  localparam int Capacity = 1024;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int IdW = 32;
  localparam int EntryW = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNSORTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]     command;
    logic [IdW-1:0] card_id;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        status;
    logic [EntryW-1:0] entry_count;
  } out_item_t;
endpackage

[design/stm_if.sv]
// Valid/ready channel interface for input items and result items.
`timescale 1ns / 1ps
interface stm_in_if;
  import stm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stm_out_if;
  import stm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/stm_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module stm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[design/sorted_id_table_membership.sv]
// Top level: sorted identifier table with append, insertion sort and binary search.
//
//   channel   direction  payload
//   in_ch     sink       command, card_id
//   out_ch    source     found, status, entry_count
//
// Clear and append pass through S_DONE, which registers the result. A query
// runs S_Q_RD, S_Q_WAIT and S_Q_CMP for each probe of the binary search (at
// most log2(count)+1 probes). Sort is an insertion sort through the single RAM
// port, shifting larger elements up before putting each key; quadratic in count.
// Reset (rst, synchronous) empties the table and marks it sorted; the RAM
// needs no clearing. A held result stalls the block until out_ch takes it.
`timescale 1ns / 1ps
module sorted_id_table_membership (
  input logic clk,
  input logic rst,
  stm_in_if.sink    in_ch,
  stm_out_if.source out_ch
);
  import stm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SORT_I, S_SORT_KEY, S_SORT_RD, S_SORT_CMP, S_SORT_PUT,
    S_Q_RD, S_Q_WAIT, S_Q_CMP, S_DONE
  } state_t;

  state_t          state;
  logic [IdW-1:0]  key;
  logic [CountW-1:0] count, i, j, lo, hi;
  logic            is_sorted;
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [IdW-1:0]  ram_wdata, ram_rdata;
  logic [CountW-1:0] mid;
  out_item_t       res;

  stm_ram #(.Width(IdW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign mid = lo + ((hi - lo) >> 1);
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign out_ch.data = res;

  // The RAM port is shared by append writes, sort reads/moves and query probes.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wdata = key;
    case (state)
      S_IDLE: begin
        ram_addr = count[AddrW-1:0];
        ram_wdata = in_ch.data.card_id;
        ram_we = in_ch.valid && in_ch.ready && (in_ch.data.command == CMD_APPEND)
                 && (count < CountW'(Capacity));
      end
      S_SORT_I:   ram_addr = i[AddrW-1:0];
      S_SORT_RD:  ram_addr = AddrW'(j - 1'b1);
      S_SORT_CMP: begin
        // Shift the larger element up one place.
        ram_addr = j[AddrW-1:0];
        ram_wdata = ram_rdata;
        ram_we = (j != '0) && (ram_rdata > key);
      end
      S_SORT_PUT: begin
        ram_addr = j[AddrW-1:0];
        ram_we = 1'b1;
      end
      S_Q_RD, S_Q_WAIT: ram_addr = mid[AddrW-1:0];
      default:    ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      is_sorted <= 1'b1;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            key <= in_ch.data.card_id;
            res.found <= 1'b0;
            res.status <= ST_OK;
            case (in_ch.data.command)
              CMD_CLEAR: begin
                count <= '0;
                is_sorted <= 1'b1;
                state <= S_DONE;
              end
              CMD_APPEND: begin
                if (count < CountW'(Capacity)) begin
                  count <= count + 1'b1;
                  is_sorted <= 1'b0;
                end else begin
                  res.status <= ST_FULL;
                end
                state <= S_DONE;
              end
              CMD_SORT: begin
                i <= CountW'(1);
                is_sorted <= 1'b1;
                state <= S_SORT_I;
              end
              default: begin
                lo <= '0;
                hi <= count;
                if (!is_sorted) begin
                  res.status <= ST_UNSORTED;
                  state <= S_DONE;
                end else begin
                  state <= S_Q_RD;
                end
              end
            endcase
          end
        end
        S_SORT_I: begin
          if (i >= count) begin
            state <= S_DONE;
          end else begin
            j <= i;
            state <= S_SORT_KEY;
          end
        end
        S_SORT_KEY: begin
          key <= ram_rdata;
          state <= S_SORT_RD;
        end
        S_SORT_RD: begin
          if (j == '0) begin
            state <= S_SORT_PUT;
          end else begin
            state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (ram_rdata > key) begin
            j <= j - 1'b1;
            state <= S_SORT_RD;
          end else begin
            state <= S_SORT_PUT;
          end
        end
        S_SORT_PUT: begin
          i <= i + 1'b1;
          state <= S_SORT_I;
        end
        S_Q_RD: begin
          if (lo < hi) begin
            state <= S_Q_WAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_WAIT: state <= S_Q_CMP;
        S_Q_CMP: begin
          if (ram_rdata == key) begin
            res.found <= 1'b1;
            state <= S_DONE;
          end else begin
            if (ram_rdata < key) begin
              lo <= mid + 1'b1;
            end else begin
              hi <= mid;
            end
            state <= S_Q_RD;
          end
        end
        S_DONE: begin
          res.entry_count <= EntryW'(count);
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
